// ===== src/hve_pkg.sv =====
// Shared types, constants and rounding and saturation helpers for the height and velocity estimator.
// Used by hve_cfg, hve_ctrl, hve_dp, height_velocity_estimator and tb_top; depends on nothing.
`default_nettype none

package hve_pkg;

    localparam int FRAC_W = 16;
    localparam int ACC_W  = 58;
    localparam int RND_W  = ACC_W - FRAC_W;
    localparam int SUM_W  = 43;
    localparam int HALF   = 32768;

    localparam logic [25:0] GRAVITY_Q16 = 26'd642908;
    localparam logic [16:0] ONE_Q16     = 17'h10000;

    typedef enum logic [2:0] {
        REG_RANGE_ALPHA    = 3'd0,
        REG_BARO_ALPHA     = 3'd1,
        REG_VELOCITY_GAIN  = 3'd2,
        REG_ACCEL_DEADBAND = 3'd3,
        REG_VELOCITY_LEAK  = 3'd4,
        REG_AGE_LIMIT      = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [16:0] range_alpha;
        logic [16:0] baro_alpha;
        logic [24:0] velocity_gain;
        logic [20:0] accel_deadband;
        logic [16:0] velocity_leak;
        logic [15:0] age_limit;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ACC_M1,
        ST_ACC_R1,
        ST_ACC_M2,
        ST_ACC_R2,
        ST_ACC_ADD,
        ST_ACC_M3,
        ST_ACC_R3,
        ST_HGT_M1,
        ST_HGT_R1,
        ST_HGT_M2,
        ST_HGT_R2,
        ST_HGT_BARO,
        ST_HGT_B2,
        ST_HGT_BR,
        ST_HGT_EST,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MA_DEAD,
        MA_TMP,
        MA_VEL,
        MA_EST,
        MA_X
    } mul_a_t;

    typedef enum logic [2:0] {
        MB_STEP,
        MB_GRAV,
        MB_LEAK,
        MB_GAIN,
        MB_ALPHA,
        MB_ALPHA_INV
    } mul_b_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_TMP,
        WB_VEL_ADD,
        WB_VEL_RND,
        WB_BASE_RND,
        WB_BASE_BARO,
        WB_EST
    } wb_t;

    typedef struct packed {
        logic   capture;
        logic   mul_en;
        logic   mul_acc;
        mul_a_t mul_a;
        mul_b_t mul_b;
        wb_t    wb;
        logic   out_load;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic baro_direct;
        logic range_mode;
        logic out_free;
    } status_t;

    // round to nearest, halves away from zero
    function automatic logic signed [RND_W-1:0] rnd16(input logic signed [ACC_W-1:0] p);
        logic signed [ACC_W-1:0] biased;
        biased = p + (p[ACC_W-1] ? ACC_W'(HALF - 1) : ACC_W'(HALF));
        return RND_W'(biased >>> FRAC_W);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] r;
        if (&v[SUM_W-1:31] || ~|v[SUM_W-1:31])
        begin
            r = v[31:0];
        end
        else if (v[SUM_W-1])
        begin
            r = {1'b1, 31'b0};
        end
        else
        begin
            r = {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/hve_cfg.sv =====
// Configuration register bank of the height and velocity estimator.
// Depends on hve_pkg for the register index codes and the cfg_t bundle.
`default_nettype none

module hve_cfg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [24:0]    cfg_data,
    output hve_pkg::cfg_t  cfg
);

    logic [16:0] range_alpha_reg;
    logic [16:0] baro_alpha_reg;
    logic [24:0] velocity_gain_reg;
    logic [20:0] accel_deadband_reg;
    logic [16:0] velocity_leak_reg;
    logic [15:0] age_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_alpha_reg    <= 17'd0;
            baro_alpha_reg     <= 17'd65339;
            velocity_gain_reg  <= 25'd65536;
            accel_deadband_reg <= 21'd2621;
            velocity_leak_reg  <= 17'd65208;
            age_limit_reg      <= 16'd50;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (hve_pkg::reg_index_t'(cfg_index))
                hve_pkg::REG_RANGE_ALPHA:    range_alpha_reg    <= cfg_data[16:0];
                hve_pkg::REG_BARO_ALPHA:     baro_alpha_reg     <= cfg_data[16:0];
                hve_pkg::REG_VELOCITY_GAIN:  velocity_gain_reg  <= cfg_data;
                hve_pkg::REG_ACCEL_DEADBAND: accel_deadband_reg <= cfg_data[20:0];
                hve_pkg::REG_VELOCITY_LEAK:  velocity_leak_reg  <= cfg_data[16:0];
                hve_pkg::REG_AGE_LIMIT:      age_limit_reg      <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // clamp weights and leak to one
    always_comb
    begin
        cfg.range_alpha    = (range_alpha_reg > hve_pkg::ONE_Q16) ? hve_pkg::ONE_Q16
                                                                  : range_alpha_reg;
        cfg.baro_alpha     = (baro_alpha_reg > hve_pkg::ONE_Q16) ? hve_pkg::ONE_Q16
                                                                 : baro_alpha_reg;
        cfg.velocity_leak  = (velocity_leak_reg > hve_pkg::ONE_Q16) ? hve_pkg::ONE_Q16
                                                                    : velocity_leak_reg;
        cfg.velocity_gain  = velocity_gain_reg;
        cfg.accel_deadband = accel_deadband_reg;
        cfg.age_limit      = age_limit_reg;
    end

endmodule

`default_nettype wire

// ===== src/hve_ctrl.sv =====
// Sequencer of the height and velocity estimator: steps the shared multiplier datapath.
// Depends on hve_pkg for state_t, cmd_t and status_t.
`default_nettype none

module hve_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  hve_pkg::status_t  status,
    output hve_pkg::cmd_t     cmd
);

    hve_pkg::state_t state_reg;
    hve_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hve_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hve_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = kind ? hve_pkg::ST_HGT_M1 : hve_pkg::ST_ACC_M1;
                end
            end
            hve_pkg::ST_ACC_M1:   state_next = hve_pkg::ST_ACC_R1;
            hve_pkg::ST_ACC_R1:   state_next = hve_pkg::ST_ACC_M2;
            hve_pkg::ST_ACC_M2:   state_next = hve_pkg::ST_ACC_R2;
            hve_pkg::ST_ACC_R2:   state_next = hve_pkg::ST_ACC_ADD;
            hve_pkg::ST_ACC_ADD:  state_next = hve_pkg::ST_ACC_M3;
            hve_pkg::ST_ACC_M3:   state_next = hve_pkg::ST_ACC_R3;
            hve_pkg::ST_ACC_R3:   state_next = hve_pkg::ST_IDLE;
            hve_pkg::ST_HGT_M1:
            begin
                state_next = status.skip ? hve_pkg::ST_OUT : hve_pkg::ST_HGT_R1;
            end
            hve_pkg::ST_HGT_R1:   state_next = hve_pkg::ST_HGT_M2;
            hve_pkg::ST_HGT_M2:   state_next = hve_pkg::ST_HGT_R2;
            hve_pkg::ST_HGT_R2:
            begin
                state_next = status.baro_direct ? hve_pkg::ST_HGT_BARO : hve_pkg::ST_HGT_B2;
            end
            hve_pkg::ST_HGT_BARO: state_next = hve_pkg::ST_HGT_EST;
            hve_pkg::ST_HGT_B2:   state_next = hve_pkg::ST_HGT_BR;
            hve_pkg::ST_HGT_BR:   state_next = hve_pkg::ST_HGT_EST;
            hve_pkg::ST_HGT_EST:  state_next = hve_pkg::ST_OUT;
            hve_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = hve_pkg::ST_IDLE;
                end
            end
            default:              state_next = hve_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.mul_en   = 1'b0;
        cmd.mul_acc  = 1'b0;
        cmd.mul_a    = hve_pkg::MA_VEL;
        cmd.mul_b    = hve_pkg::MB_STEP;
        cmd.wb       = hve_pkg::WB_NONE;
        cmd.out_load = 1'b0;
        case (state_reg)
            hve_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            hve_pkg::ST_ACC_M1:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_a  = hve_pkg::MA_DEAD;
                cmd.mul_b  = hve_pkg::MB_STEP;
            end
            hve_pkg::ST_ACC_R1:   cmd.wb = hve_pkg::WB_TMP;
            hve_pkg::ST_ACC_M2:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_a  = hve_pkg::MA_TMP;
                cmd.mul_b  = hve_pkg::MB_GRAV;
            end
            hve_pkg::ST_ACC_R2:   cmd.wb = hve_pkg::WB_TMP;
            hve_pkg::ST_ACC_ADD:  cmd.wb = hve_pkg::WB_VEL_ADD;
            hve_pkg::ST_ACC_M3:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_a  = hve_pkg::MA_VEL;
                cmd.mul_b  = hve_pkg::MB_LEAK;
            end
            hve_pkg::ST_ACC_R3:   cmd.wb = hve_pkg::WB_VEL_RND;
            hve_pkg::ST_HGT_M1:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_a  = hve_pkg::MA_VEL;
                cmd.mul_b  = hve_pkg::MB_STEP;
            end
            hve_pkg::ST_HGT_R1:   cmd.wb = hve_pkg::WB_TMP;
            hve_pkg::ST_HGT_M2:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_a  = hve_pkg::MA_TMP;
                cmd.mul_b  = hve_pkg::MB_GAIN;
            end
            hve_pkg::ST_HGT_R2:
            begin
                cmd.wb     = hve_pkg::WB_TMP;
                cmd.mul_en = 1'b1;
                cmd.mul_a  = hve_pkg::MA_EST;
                cmd.mul_b  = hve_pkg::MB_ALPHA;
            end
            hve_pkg::ST_HGT_BARO: cmd.wb = hve_pkg::WB_BASE_BARO;
            hve_pkg::ST_HGT_B2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_acc = 1'b1;
                cmd.mul_a   = hve_pkg::MA_X;
                cmd.mul_b   = hve_pkg::MB_ALPHA_INV;
            end
            hve_pkg::ST_HGT_BR:   cmd.wb = hve_pkg::WB_BASE_RND;
            hve_pkg::ST_HGT_EST:  cmd.wb = hve_pkg::WB_EST;
            hve_pkg::ST_OUT:      cmd.out_load = status.out_free;
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/hve_dp.sv =====
// Datapath of the height and velocity estimator: input capture, shared multiplier,
// rounding, filter state and output register. Depends on hve_pkg.
`default_nettype none

module hve_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  hve_pkg::cmd_t      cmd,
    output hve_pkg::status_t   status,
    input  hve_pkg::cfg_t      cfg,
    input  logic               kind,
    input  logic signed [31:0] accel_z,
    input  logic signed [31:0] baro_height,
    input  logic signed [31:0] range_distance,
    input  logic [31:0]        range_stamp,
    input  logic [31:0]        now_tick,
    input  logic [15:0]        step_time,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] height
);

    logic signed [31:0]                 d_reg;
    logic signed [31:0]                 baro_reg;
    logic signed [31:0]                 dist_reg;
    logic [15:0]                        dt_reg;
    logic                               fresh_reg;
    logic                               range_mode_reg;
    logic signed [31:0]                 est_reg;
    logic signed [31:0]                 vel_reg;
    logic signed [hve_pkg::ACC_W-1:0]   acc_reg;
    logic signed [hve_pkg::RND_W-1:0]   tmp_reg;
    logic signed [31:0]                 base_reg;
    logic                               out_valid_reg;
    logic signed [31:0]                 height_reg;

    logic signed [32:0]                 a_ext;
    logic signed [32:0]                 band_ext;
    logic signed [32:0]                 mag;
    logic signed [32:0]                 d_ext;
    logic [31:0]                        age;
    logic                               fresh;
    logic [16:0]                        alpha;
    logic signed [31:0]                 op_a;
    logic signed [25:0]                 op_b;
    logic signed [hve_pkg::ACC_W-1:0]   prod;
    logic signed [hve_pkg::RND_W-1:0]   rnd;

    // deadband on the incoming acceleration
    always_comb
    begin
        a_ext    = 33'(accel_z);
        band_ext = {12'b0, cfg.accel_deadband};
        mag      = (a_ext < 0) ? -a_ext : a_ext;
        if (mag < band_ext)
        begin
            d_ext = '0;
        end
        else if (a_ext > 0)
        begin
            d_ext = a_ext - band_ext;
        end
        else
        begin
            d_ext = a_ext + band_ext;
        end
    end

    assign age   = now_tick - range_stamp;
    assign fresh = (age <= {16'b0, cfg.age_limit});
    assign alpha = range_mode_reg ? cfg.range_alpha : cfg.baro_alpha;

    always_comb
    begin
        case (cmd.mul_a)
            hve_pkg::MA_DEAD: op_a = d_reg;
            hve_pkg::MA_TMP:  op_a = tmp_reg[31:0];
            hve_pkg::MA_VEL:  op_a = vel_reg;
            hve_pkg::MA_EST:  op_a = est_reg;
            hve_pkg::MA_X:    op_a = range_mode_reg ? dist_reg : baro_reg;
            default:          op_a = vel_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.mul_b)
            hve_pkg::MB_STEP:      op_b = {10'b0, dt_reg};
            hve_pkg::MB_GRAV:      op_b = hve_pkg::GRAVITY_Q16;
            hve_pkg::MB_LEAK:      op_b = {9'b0, cfg.velocity_leak};
            hve_pkg::MB_GAIN:      op_b = {1'b0, cfg.velocity_gain};
            hve_pkg::MB_ALPHA:     op_b = {9'b0, alpha};
            hve_pkg::MB_ALPHA_INV: op_b = {9'b0, hve_pkg::ONE_Q16 - alpha};
            default:               op_b = {10'b0, dt_reg};
        endcase
    end

    assign prod = hve_pkg::ACC_W'(op_a) * hve_pkg::ACC_W'(op_b);
    assign rnd  = hve_pkg::rnd16(acc_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            d_reg    <= d_ext[31:0];
            baro_reg <= baro_height;
            dist_reg <= range_distance;
            dt_reg   <= step_time;
        end
        if (cmd.mul_en)
        begin
            acc_reg <= cmd.mul_acc ? acc_reg + prod : prod;
        end
        if (cmd.wb == hve_pkg::WB_TMP)
        begin
            tmp_reg <= rnd;
        end
        if (cmd.wb == hve_pkg::WB_BASE_RND)
        begin
            base_reg <= rnd[31:0];
        end
        if (cmd.wb == hve_pkg::WB_BASE_BARO)
        begin
            base_reg <= baro_reg;
        end
        if (cmd.out_load)
        begin
            height_reg <= est_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg      <= 1'b0;
            range_mode_reg <= 1'b0;
            est_reg        <= '0;
            vel_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                fresh_reg <= fresh;
                if (kind && fresh)
                begin
                    range_mode_reg <= 1'b1;
                end
            end
            case (cmd.wb)
                hve_pkg::WB_VEL_ADD:
                begin
                    vel_reg <= hve_pkg::sat32(hve_pkg::SUM_W'(vel_reg)
                                              + hve_pkg::SUM_W'(tmp_reg));
                end
                hve_pkg::WB_VEL_RND:
                begin
                    vel_reg <= hve_pkg::sat32(hve_pkg::SUM_W'(rnd));
                end
                hve_pkg::WB_EST:
                begin
                    est_reg <= hve_pkg::sat32(hve_pkg::SUM_W'(base_reg)
                                              + hve_pkg::SUM_W'(tmp_reg));
                end
                default:
                begin
                end
            endcase
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.skip        = range_mode_reg && !fresh_reg;
    assign status.baro_direct = !range_mode_reg && (est_reg == 32'sd0);
    assign status.range_mode  = range_mode_reg;
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign height    = height_reg;

endmodule

`default_nettype wire

// ===== src/height_velocity_estimator.sv =====
// Top level of the height and velocity estimator: register bank, sequencer and datapath.
// Depends on hve_pkg, hve_cfg, hve_ctrl and hve_dp.
`default_nettype none

// Complementary-filter height estimator in Q16.16. An acceleration transaction (kind 0)
// updates the vertical velocity and returns nothing; a height transaction (kind 1)
// blends laser range or barometer into the estimate, adds the velocity term and returns
// the saturated height. One 32 x 26 bit multiplier, followed by an accumulator register
// whose output is rounded, is shared by every step, so items run one at a time. A height
// item takes the barometer directly while the estimate is zero in barometer mode, and a
// stale range sample leaves the estimate alone; a height item ends only after any
// previous result waiting at the output has been taken. A waiting result does not stop
// the next item from being accepted. Configuration writes are always accepted and take
// effect on the next cycle.
module height_velocity_estimator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [24:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic signed [31:0] accel_z,
    input  logic signed [31:0] baro_height,
    input  logic signed [31:0] range_distance,
    input  logic [31:0]        range_stamp,
    input  logic [31:0]        now_tick,
    input  logic [15:0]        step_time,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] height
);

    hve_pkg::cfg_t    cfg;
    hve_pkg::cmd_t    cmd;
    hve_pkg::status_t status;

    hve_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hve_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd)
    );

    hve_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg            (cfg),
        .kind           (kind),
        .accel_z        (accel_z),
        .baro_height    (baro_height),
        .range_distance (range_distance),
        .range_stamp    (range_stamp),
        .now_tick       (now_tick),
        .step_time      (step_time),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .height         (height)
    );

    a_accel_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !kind) |=> !$rose(out_valid))
        else $error("acceleration transaction produced a result");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transaction accepted while one is in progress");

    a_range_mode_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(status.range_mode))
        else $error("range mode dropped after being latched");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for height_velocity_estimator: barometer and laser range fusion
// with a velocity term, checked transaction by transaction against a predictor held here.
// Depends on hve_pkg and the height_velocity_estimator RTL.
`default_nettype none

module tb_top;

    localparam logic KIND_ACCEL  = 1'b0;
    localparam logic KIND_HEIGHT = 1'b1;

    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic        kind;
        logic [31:0] accel_z;
        logic [31:0] baro_height;
        logic [31:0] range_distance;
        logic [31:0] range_stamp;
        logic [31:0] now_tick;
        logic [15:0] step_time;
    } sensor_item_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [24:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               kind;
    logic signed [31:0] accel_z;
    logic signed [31:0] baro_height;
    logic signed [31:0] range_distance;
    logic [31:0]        range_stamp;
    logic [31:0]        now_tick;
    logic [15:0]        step_time;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] height;

    logic [16:0] cfg_range_alpha;
    logic [16:0] cfg_baro_alpha;
    logic [24:0] cfg_gain;
    logic [20:0] cfg_deadband;
    logic [16:0] cfg_leak;
    logic [15:0] cfg_max_age;

    longint est_height;
    longint est_velocity;
    bit     range_latched;

    logic [31:0] expected_heights[$];
    logic [31:0] wanted_height;

    int  error_count    = 0;
    int  heights_seen   = 0;
    int  items_sent     = 0;
    int  register_writes = 0;
    int  hold_request   = 0;
    bit  idle_free      = 1'b0;

    height_velocity_estimator uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .accel_z        (accel_z),
        .baro_height    (baro_height),
        .range_distance (range_distance),
        .range_stamp    (range_stamp),
        .now_tick       (now_tick),
        .step_time      (step_time),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .height         (height)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint round_q16(input longint v);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + 64'sd32768) >> 16;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint clip_s32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint unit_clamp(input logic [16:0] a);
        return (a > hve_pkg::ONE_Q16) ? longint'(hve_pkg::ONE_Q16) : longint'(a);
    endfunction

    function automatic longint iir_mix(input logic [16:0] weight, input longint old_v,
                                       input longint new_v);
        longint w;
        w = unit_clamp(weight);
        return round_q16(w * old_v + (64'sd65536 - w) * new_v);
    endfunction

    function automatic void reset_estimator_model();
        cfg_range_alpha = 17'd0;
        cfg_baro_alpha  = 17'd65339;
        cfg_gain        = 25'd65536;
        cfg_deadband    = 21'd2621;
        cfg_leak        = 17'd65208;
        cfg_max_age     = 16'd50;
        est_height      = 0;
        est_velocity    = 0;
        range_latched   = 1'b0;
    endfunction

    function automatic void advance_estimate(input sensor_item_t it);
        longint accel;
        longint band;
        longint mag;
        longint d;
        longint a1;
        longint dv;
        longint vd;
        longint term;
        longint base;
        logic [31:0] age;
        bit fresh;
        if (it.kind == KIND_ACCEL)
        begin
            accel = longint'($signed(it.accel_z));
            band  = longint'(cfg_deadband);
            mag   = (accel < 0) ? -accel : accel;
            if (mag < band)
            begin
                d = 0;
            end
            else if (accel > 0)
            begin
                d = accel - band;
            end
            else
            begin
                d = accel + band;
            end
            a1 = round_q16(d * longint'(it.step_time));
            dv = round_q16(a1 * longint'(hve_pkg::GRAVITY_Q16));
            est_velocity = clip_s32(est_velocity + dv);
            est_velocity = clip_s32(round_q16(est_velocity * unit_clamp(cfg_leak)));
        end
        else
        begin
            age   = it.now_tick - it.range_stamp;
            fresh = (age <= {16'd0, cfg_max_age});
            vd    = round_q16(est_velocity * longint'(it.step_time));
            term  = round_q16(longint'(cfg_gain) * vd);
            if (fresh)
            begin
                range_latched = 1'b1;
            end
            if (range_latched)
            begin
                if (fresh)
                begin
                    base = iir_mix(cfg_range_alpha, est_height,
                                   longint'($signed(it.range_distance)));
                    est_height = clip_s32(base + term);
                end
            end
            else
            begin
                if (est_height == 0)
                begin
                    base = longint'($signed(it.baro_height));
                end
                else
                begin
                    base = iir_mix(cfg_baro_alpha, est_height,
                                   longint'($signed(it.baro_height)));
                end
                est_height = clip_s32(base + term);
            end
            expected_heights.push_back(est_height[31:0]);
        end
    endfunction

    function automatic sensor_item_t make_accel(input logic [31:0] a, input logic [15:0] dt);
        sensor_item_t it;
        it.kind           = KIND_ACCEL;
        it.accel_z        = a;
        it.baro_height    = $urandom;
        it.range_distance = $urandom;
        it.range_stamp    = $urandom;
        it.now_tick       = $urandom;
        it.step_time      = dt;
        return it;
    endfunction

    function automatic sensor_item_t make_height(input logic [31:0] baro,
                                                 input logic [31:0] range_dist,
                                                 input logic [31:0] stamp, input logic [31:0] now,
                                                 input logic [15:0] dt);
        sensor_item_t it;
        it.kind           = KIND_HEIGHT;
        it.accel_z        = $urandom;
        it.baro_height    = baro;
        it.range_distance = range_dist;
        it.range_stamp    = stamp;
        it.now_tick       = now;
        it.step_time      = dt;
        return it;
    endfunction

    function automatic logic [31:0] pick_distance();
        logic [31:0] m;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: m = $urandom_range(0, 65536);
            default: m = $urandom_range(0, 1 << 22);
        endcase
        return $urandom_range(0, 1) ? m : -m;
    endfunction

    function automatic logic [31:0] pick_accel();
        logic [31:0] m;
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: m = {11'd0, cfg_deadband} + $urandom_range(0, 8) - 4;
            2: m = $urandom_range(0, 1 << 18);
            3: m = $urandom_range(0, 1 << 12);
            default:
            begin
                case ($urandom_range(0, 2))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    default: return 32'h0;
                endcase
            end
        endcase
        return $urandom_range(0, 1) ? m : -m;
    endfunction

    function automatic logic [15:0] pick_step();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 700));
            1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [31:0] pick_age(input bit may_be_fresh);
        logic [31:0] age;
        if (may_be_fresh && $urandom_range(0, 1))
        begin
            age = $urandom_range(0, cfg_max_age);
        end
        else if ($urandom_range(0, 1))
        begin
            age = {16'd0, cfg_max_age} + 32'd1 + $urandom_range(0, 3);
        end
        else
        begin
            age = $urandom;
            if (age <= {16'd0, cfg_max_age})
            begin
                age = age + {16'd0, cfg_max_age} + 32'd1;
            end
        end
        return age;
    endfunction

    function automatic sensor_item_t random_item(input bit may_be_fresh);
        sensor_item_t it;
        it.kind           = 1'($urandom_range(0, 1));
        it.accel_z        = pick_accel();
        it.baro_height    = pick_distance();
        it.range_distance = pick_distance();
        it.range_stamp    = $urandom;
        it.now_tick       = it.range_stamp + pick_age(may_be_fresh);
        it.step_time      = pick_step();
        return it;
    endfunction

    task automatic send_item(input sensor_item_t it);
        int gap;
        gap = idle_free ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        kind           <= it.kind;
        accel_z        <= it.accel_z;
        baro_height    <= it.baro_height;
        range_distance <= it.range_distance;
        range_stamp    <= it.range_stamp;
        now_tick       <= it.now_tick;
        step_time      <= it.step_time;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        advance_estimate(it);
        items_sent++;
    endtask

    task automatic wait_until_settled();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_heights.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [24:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (index)
            hve_pkg::REG_RANGE_ALPHA:    cfg_range_alpha = data[16:0];
            hve_pkg::REG_BARO_ALPHA:     cfg_baro_alpha  = data[16:0];
            hve_pkg::REG_VELOCITY_GAIN:  cfg_gain        = data[24:0];
            hve_pkg::REG_ACCEL_DEADBAND: cfg_deadband    = data[20:0];
            hve_pkg::REG_VELOCITY_LEAK:  cfg_leak        = data[16:0];
            hve_pkg::REG_AGE_LIMIT:      cfg_max_age     = data[15:0];
            default: ;
        endcase
        register_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [24:0] range_a, input logic [24:0] baro_a,
                                  input logic [24:0] gain, input logic [24:0] band,
                                  input logic [24:0] leak, input logic [24:0] max_age);
        wait_until_settled();
        write_register(hve_pkg::REG_RANGE_ALPHA, range_a);
        write_register(hve_pkg::REG_BARO_ALPHA, baro_a);
        write_register(hve_pkg::REG_VELOCITY_GAIN, gain);
        write_register(hve_pkg::REG_ACCEL_DEADBAND, band);
        write_register(hve_pkg::REG_VELOCITY_LEAK, leak);
        write_register(hve_pkg::REG_AGE_LIMIT, max_age);
    endtask

    task automatic run_random(input int count, input bit may_be_fresh);
        idle_free = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            if (i == count - count / 3)
            begin
                idle_free = 1'b1;
            end
            send_item(random_item(may_be_fresh));
        end
        idle_free = 1'b0;
    endtask

    task automatic test_barometer_directed();
        send_item(make_height(32'd655360, 32'd0, 32'd0, 32'd1000, 16'd66));
        send_item(make_accel(32'd2620, 16'hFFFF));
        send_item(make_accel(32'd2621, 16'hFFFF));
        send_item(make_accel(-32'd2621, 16'hFFFF));
        send_item(make_accel(32'h7FFF_FFFF, 16'hFFFF));
        send_item(make_height(-32'd327680, 32'd0, 32'd0, 32'd1000, 16'hFFFF));
        send_item(make_accel(32'h8000_0000, 16'hFFFF));
        send_item(make_accel(32'h8000_0000, 16'hFFFF));
        send_item(make_height(32'h8000_0000, 32'd0, 32'd5, 32'd1000, 16'hFFFF));
        send_item(make_accel(32'h1234_5678, 16'd0));
    endtask

    task automatic test_zero_estimate_restart();
        wait_until_settled();
        write_register(hve_pkg::REG_VELOCITY_LEAK, 25'd0);
        write_register(hve_pkg::REG_BARO_ALPHA, 25'd0);
        send_item(make_accel(32'd0, 16'd0));
        send_item(make_height(32'd0, 32'd0, 32'd0, 32'd1000, 16'd100));
        send_item(make_height(32'd1234567, 32'd0, 32'd0, 32'd1000, 16'd100));
        wait_until_settled();
        write_register(hve_pkg::REG_BARO_ALPHA, 25'h1FFFF);
        send_item(make_height(-32'd777, 32'd0, 32'd0, 32'd1000, 16'd100));
    endtask

    task automatic test_barometer_random();
        wait_until_settled();
        write_register(REG_SPARE_LO, 25'($urandom));
        write_register(REG_SPARE_HI, 25'($urandom));
        apply_settings(25'd0, 25'd65339, 25'd65536, 25'd2621, 25'd65208, 25'd50);
        run_random(60, 1'b0);
        apply_settings(25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF,
                       25'h1FFFFFF);
        run_random(60, 1'b0);
        apply_settings(25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0);
        run_random(60, 1'b0);
    endtask

    task automatic test_range_entry();
        apply_settings(25'd32768, 25'd65339, 25'd65536, 25'd2621, 25'd65208, 25'd50);
        send_item(make_height(32'd65536, 32'd131072, 32'd100, 32'd151, 16'd66));
        send_item(make_height(32'd65536, 32'd196608, 32'hFFFF_FFF0, 32'h0000_0022, 16'd66));
        send_item(make_height(32'd65536, 32'd262144, 32'd0, 32'h8000_0000, 16'd66));
        send_item(make_accel(32'h0004_0000, 16'hFFFF));
        send_item(make_height(32'd0, 32'd0, 32'd10, 32'd9, 16'hFFFF));
        wait_until_settled();
        write_register(hve_pkg::REG_RANGE_ALPHA, 25'd0);
        send_item(make_height(32'd0, 32'h7FFF_FFFF, 32'd7, 32'd7, 16'd500));
        wait_until_settled();
        write_register(hve_pkg::REG_RANGE_ALPHA, 25'd65536);
        send_item(make_height(32'd0, 32'h8000_0000, 32'd7, 32'd57, 16'd500));
        wait_until_settled();
        write_register(hve_pkg::REG_RANGE_ALPHA, 25'd65537);
        send_item(make_height(32'd0, 32'h8000_0000, 32'd7, 32'd20, 16'd500));
    endtask

    task automatic test_range_random();
        apply_settings(25'd0, 25'd65339, 25'd65536, 25'd2621, 25'd65208, 25'd50);
        run_random(85, 1'b1);
        apply_settings(25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0);
        run_random(85, 1'b1);
        apply_settings(25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF,
                       25'h1FFFFFF);
        run_random(85, 1'b1);
        apply_settings(25'($urandom), 25'($urandom), 25'($urandom), 25'($urandom),
                       25'($urandom), 25'($urandom));
        run_random(85, 1'b1);
        apply_settings(25'($urandom_range(0, 65536)), 25'($urandom_range(0, 65536)),
                       25'($urandom_range(0, 1 << 17)), 25'($urandom_range(0, 8000)),
                       25'($urandom_range(60000, 65536)), 25'($urandom_range(0, 200)));
        run_random(85, 1'b1);
    endtask

    task automatic test_output_backpressure();
        wait_until_settled();
        hold_request = 200;
        idle_free    = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            send_item(random_item(1'b1));
        end
        idle_free = 1'b0;
    endtask

    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                stall        = hold_request;
                hold_request = 0;
            end
            else
            begin
                stall = idle_free ? 0 : $urandom_range(0, 14);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_heights.size() == 0)
            begin
                $error("height: no result expected, actual %0d", height);
                error_count++;
            end
            else
            begin
                wanted_height = expected_heights.pop_front();
                heights_seen++;
                if (height !== wanted_height)
                begin
                    $error("height: expected %0d, actual %0d", $signed(wanted_height), height);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : run_tests
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = hve_pkg::REG_RANGE_ALPHA;
        cfg_data       = 25'd0;
        in_valid       = 1'b0;
        kind           = KIND_ACCEL;
        accel_z        = 32'sd0;
        baro_height    = 32'sd0;
        range_distance = 32'sd0;
        range_stamp    = 32'd0;
        now_tick       = 32'd0;
        step_time      = 16'd0;
        reset_estimator_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_barometer_directed();
        test_zero_estimate_restart();
        test_barometer_random();
        test_range_entry();
        test_range_random();
        test_output_backpressure();

        wait_until_settled();
        $display("Sent %0d sensor transactions, checked %0d heights in barometer and range mode,",
                 items_sent, heights_seen);
        $display("with %0d register writes, idle-free bursts and a long output hold-off.",
                 register_writes);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(12 * 600000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
